[rtl/whsas_pkg.sv]
// whsas_pkg: shared constants, widths and the queue entry type for the
// weekly hours sort and stats block; no dependencies
package whsas_pkg;

  localparam int unsigned DAYS_DEF   = 7;
  localparam int unsigned HOURS_W    = 11;
  localparam int unsigned TOTAL_W    = 14;
  localparam int unsigned SMALL_W    = 3;
  localparam int unsigned TOTAL_MAX  = 16383;
  localparam int unsigned SMALL_MAX  = 7;

  localparam logic [HOURS_W-1:0] HOURS_MAX = 11'd1500;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // register index, taken from paddr[2]
  localparam logic REG_IDX_TARGET = 1'b0;

  typedef struct packed {
    logic [HOURS_W-1:0] hours;
    logic               last;
  } entry_t;

endpackage

[rtl/whsas_front.sv]
// whsas_front: input side, saturates each value and tags the last of a set
// depends on whsas_pkg
module whsas_front
  import whsas_pkg::*;
#(
  parameter int unsigned DAYS = DAYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [HOURS_W-1:0] hours_i,
  input  logic               fifo_full_i,
  output logic               wr_en_o,
  output entry_t             entry_o
);

  localparam int unsigned IDX_W = $clog2(DAYS);

  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign accept        = push_i & ~fifo_full_i;
  assign wr_en_o       = accept;
  assign entry_o.hours = (hours_i > HOURS_MAX) ? HOURS_MAX : hours_i;
  assign entry_o.last  = (cnt_q == IDX_W'(DAYS - 1));

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = entry_o.last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[rtl/whsas_fifo.sv]
// whsas_fifo: short queue between the input side and the sort engine
// depends on whsas_pkg
module whsas_fifo
  import whsas_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   wr_en_i,
  input  entry_t wr_data_i,
  input  logic   rd_en_i,
  output entry_t rd_data_o,
  output logic   full_o,
  output logic   empty_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_wr, do_rd;

  assign full_o    = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i & ~full_o;
  assign do_rd     = rd_en_i & ~empty_o;
  assign rd_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/whsas_back.sv]
// whsas_back: collects a set, counts met days, runs an odd-even transposition sort
// and shifts the sorted set out, average by reciprocal multiply; depends on whsas_pkg
module whsas_back
  import whsas_pkg::*;
#(
  parameter int unsigned DAYS = DAYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fifo_empty_i,
  input  entry_t             entry_i,
  output logic               fifo_pop_o,
  input  logic [HOURS_W-1:0] target_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [HOURS_W-1:0] sorted_hours_o,
  output logic               last_out_o,
  output logic [TOTAL_W-1:0] total_hours_o,
  output logic [HOURS_W-1:0] average_hours_o,
  output logic [SMALL_W-1:0] busiest_day_o,
  output logic [SMALL_W-1:0] lightest_day_o,
  output logic [SMALL_W-1:0] met_count_o,
  output logic [SMALL_W-1:0] missed_count_o
);

  localparam int unsigned IDX_W   = $clog2(DAYS);
  localparam int unsigned TOT_W   = $clog2(DAYS * 1500 + 1);
  localparam int unsigned MC_W    = $clog2(DAYS + 1);
  localparam int unsigned CALC_N  = 2 * DAYS;
  localparam int unsigned CALC_W  = $clog2(CALC_N);
  // exact quotient for any total below 2**TOT_W
  localparam int unsigned RECIP_S = TOT_W + IDX_W;
  localparam int unsigned RECIP_M = ((1 << RECIP_S) + DAYS - 1) / DAYS;
  localparam int unsigned PROD_W  = 2 * TOT_W + 1;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [IDX_W-1:0]   fill_q, fill_d;
  logic [CALC_W-1:0]  calc_q, calc_d;
  logic [IDX_W-1:0]   emit_q, emit_d;

  logic [HOURS_W-1:0] sort_q [DAYS];
  logic [HOURS_W-1:0] sort_d [DAYS];
  logic [TOT_W-1:0]   total_q, total_d;
  logic [HOURS_W-1:0] max_val_q, max_val_d, min_val_q, min_val_d;
  logic [IDX_W-1:0]   max_idx_q, max_idx_d, min_idx_q, min_idx_d;
  logic [MC_W-1:0]    met_q, met_d;

  logic [HOURS_W-1:0] v;
  logic [MC_W-1:0]    missed;
  logic [PROD_W-1:0]  avg_prod;

  assign v        = entry_i.hours;
  assign missed   = MC_W'(DAYS) - met_q;
  assign avg_prod = PROD_W'(total_q) * PROD_W'(RECIP_M);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    calc_d     = calc_q;
    emit_d     = emit_q;
    sort_d     = sort_q;
    total_d    = total_q;
    max_val_d  = max_val_q;
    max_idx_d  = max_idx_q;
    min_val_d  = min_val_q;
    min_idx_d  = min_idx_q;
    met_d      = met_q;
    fifo_pop_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        if (!fifo_empty_i) begin
          fifo_pop_o     = 1'b1;
          sort_d[fill_q] = v;
          if (fill_q == '0) begin
            total_d   = TOT_W'(v);
            max_val_d = v;
            max_idx_d = '0;
            min_val_d = v;
            min_idx_d = '0;
          end else begin
            total_d = total_q + TOT_W'(v);
            if (v > max_val_q) begin
              max_val_d = v;
              max_idx_d = fill_q;
            end
            if (v < min_val_q) begin
              min_val_d = v;
              min_idx_d = fill_q;
            end
          end
          if (entry_i.last) begin
            state_d = ST_CALC;
            fill_d  = '0;
            calc_d  = '0;
            met_d   = '0;
          end else begin
            fill_d = fill_q + 1'b1;
          end
        end
      end
      ST_CALC: begin
        // first DAYS steps count met days, the rest sort
        if (calc_q < CALC_W'(DAYS)) begin
          if (sort_q[calc_q[IDX_W-1:0]] >= target_i) begin
            met_d = met_q + 1'b1;
          end
        end else begin
          for (int j = 0; j < DAYS - 1; j++) begin
            if ((j[0] == calc_q[0]) && (sort_q[j] < sort_q[j+1])) begin
              sort_d[j]   = sort_q[j+1];
              sort_d[j+1] = sort_q[j];
            end
          end
        end
        if (calc_q == CALC_W'(CALC_N - 1)) begin
          state_d = ST_EMIT;
          emit_d  = '0;
        end else begin
          calc_d = calc_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (pop_i) begin
          for (int j = 0; j < DAYS - 1; j++) begin
            sort_d[j] = sort_q[j+1];
          end
          if (emit_q == IDX_W'(DAYS - 1)) begin
            state_d = ST_LOAD;
          end
          emit_d = emit_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      calc_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      calc_q  <= calc_d;
      emit_q  <= emit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sort_q    <= sort_d;
    total_q   <= total_d;
    max_val_q <= max_val_d;
    max_idx_q <= max_idx_d;
    min_val_q <= min_val_d;
    min_idx_q <= min_idx_d;
    met_q     <= met_d;
  end

  assign empty_o         = (state_q != ST_EMIT);
  assign sorted_hours_o  = sort_q[0];
  assign last_out_o      = (emit_q == IDX_W'(DAYS - 1));
  assign total_hours_o   = (32'(total_q) > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(total_q);
  assign average_hours_o = HOURS_W'(avg_prod >> RECIP_S);
  assign busiest_day_o   = (32'(max_idx_q) > SMALL_MAX) ? SMALL_W'(SMALL_MAX)
                                                        : SMALL_W'(max_idx_q);
  assign lightest_day_o  = (32'(min_idx_q) > SMALL_MAX) ? SMALL_W'(SMALL_MAX)
                                                        : SMALL_W'(min_idx_q);
  assign met_count_o     = (32'(met_q) > SMALL_MAX) ? SMALL_W'(SMALL_MAX) : SMALL_W'(met_q);
  assign missed_count_o  = (32'(missed) > SMALL_MAX) ? SMALL_W'(SMALL_MAX) : SMALL_W'(missed);

endmodule

[rtl/weekly_hours_sort_and_stats.sv]
// weekly_hours_sort_and_stats: top level with the target register port
// depends on whsas_pkg, whsas_front, whsas_fifo, whsas_back
//
// Takes DAYS hour values (hundredths, saturated at 1500) one per push, and after
// the last value of a set presents the set in descending order, one value per pop,
// each carrying total, average, first max and min index and met/missed counts
// against target_hours. Values enter a two-entry queue at one per cycle while it is
// not full, and the sort engine drains it at one per cycle while collecting a set.
// After the last value of a set the engine first counts met days, then runs odd-even
// transposition passes; the average is a reciprocal multiply of the total. It then
// offers DAYS results, one per cycle when popped; new values wait in the queue until
// the last result is taken.
module weekly_hours_sort_and_stats
  import whsas_pkg::*;
#(
  parameter int unsigned DAYS = DAYS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [HOURS_W-1:0] hours_i,
  output logic               empty,
  input  logic               pop,
  output logic [HOURS_W-1:0] sorted_hours_o,
  output logic               last_out_o,
  output logic [TOTAL_W-1:0] total_hours_o,
  output logic [HOURS_W-1:0] average_hours_o,
  output logic [SMALL_W-1:0] busiest_day_o,
  output logic [SMALL_W-1:0] lightest_day_o,
  output logic [SMALL_W-1:0] met_count_o,
  output logic [SMALL_W-1:0] missed_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [HOURS_W-1:0] target_q, target_d;
  logic               cfg_wr;
  logic               fifo_wr, fifo_rd, fifo_full, fifo_empty;
  entry_t             wr_entry, rd_entry;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & (paddr[2] == REG_IDX_TARGET);
  assign prdata = (paddr[2] == REG_IDX_TARGET) ? DATA_W'(target_q) : '0;

  always_comb begin
    target_d = target_q;
    if (cfg_wr) begin
      target_d = pwdata[HOURS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else begin
      target_q <= target_d;
    end
  end

  assign full = fifo_full;

  whsas_front #(
    .DAYS (DAYS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .hours_i     (hours_i),
    .fifo_full_i (fifo_full),
    .wr_en_o     (fifo_wr),
    .entry_o     (wr_entry)
  );

  whsas_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (fifo_wr),
    .wr_data_i (wr_entry),
    .rd_en_i   (fifo_rd),
    .rd_data_o (rd_entry),
    .full_o    (fifo_full),
    .empty_o   (fifo_empty)
  );

  whsas_back #(
    .DAYS (DAYS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_empty_i    (fifo_empty),
    .entry_i         (rd_entry),
    .fifo_pop_o      (fifo_rd),
    .target_i        (target_q),
    .pop_i           (pop),
    .empty_o         (empty),
    .sorted_hours_o  (sorted_hours_o),
    .last_out_o      (last_out_o),
    .total_hours_o   (total_hours_o),
    .average_hours_o (average_hours_o),
    .busiest_day_o   (busiest_day_o),
    .lightest_day_o  (lightest_day_o),
    .met_count_o     (met_count_o),
    .missed_count_o  (missed_count_o)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// testbench: self-checking bench for weekly_hours_sort_and_stats, with a queue-fed
// driver, a monitor with a descending-sort and week statistics predictor, and APB setup
// depends on whsas_pkg and the rtl of weekly_hours_sort_and_stats
module testbench;
  import whsas_pkg::*;

  localparam int unsigned DAYS = DAYS_DEF;
  localparam logic [ADDR_W-1:0] TARGET_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] SPARE_ADDR = 3'd4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef enum {PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_e;

  typedef struct packed {
    logic [HOURS_W-1:0] sorted;
    logic               last;
    logic [TOTAL_W-1:0] total;
    logic [HOURS_W-1:0] average;
    logic [SMALL_W-1:0] busiest;
    logic [SMALL_W-1:0] lightest;
    logic [SMALL_W-1:0] met;
    logic [SMALL_W-1:0] missed;
  } ranked_day_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [HOURS_W-1:0] hours_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [HOURS_W-1:0] sorted_hours_o;
  logic               last_out_o;
  logic [TOTAL_W-1:0] total_hours_o;
  logic [HOURS_W-1:0] average_hours_o;
  logic [SMALL_W-1:0] busiest_day_o;
  logic [SMALL_W-1:0] lightest_day_o;
  logic [SMALL_W-1:0] met_count_o;
  logic [SMALL_W-1:0] missed_count_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;

  logic [HOURS_W-1:0] hours_backlog[$];
  ranked_day_t        ranked_days_due[$];
  logic [HOURS_W-1:0] week_vals[DAYS];
  int unsigned        week_fill = 0;
  logic [HOURS_W-1:0] goal_hours = '0;
  pace_e              pace = PACE_FREE;
  logic               in_fire = 1'b0;
  int unsigned        hold_req = 0;
  int unsigned        hold_taken = 0;
  int unsigned        hold_left = 0;
  int unsigned        quiet_cycles = 0;
  int unsigned        mismatches = 0;

  weekly_hours_sort_and_stats i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .hours_i        (hours_i),
    .empty          (empty),
    .pop            (pop),
    .sorted_hours_o (sorted_hours_o),
    .last_out_o     (last_out_o),
    .total_hours_o  (total_hours_o),
    .average_hours_o(average_hours_o),
    .busiest_day_o  (busiest_day_o),
    .lightest_day_o (lightest_day_o),
    .met_count_o    (met_count_o),
    .missed_count_o (missed_count_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned clip(int unsigned v, int unsigned top);
    return (v > top) ? top : v;
  endfunction

  // store one day and, on the last day of the week, rank the week
  task automatic record_day(input logic [HOURS_W-1:0] raw);
    logic [HOURS_W-1:0] order[DAYS];
    logic [HOURS_W-1:0] swap;
    int unsigned sum;
    int unsigned top_idx;
    int unsigned low_idx;
    int unsigned hits;
    int unsigned misses;
    ranked_day_t r;
    week_vals[week_fill] = (raw > HOURS_MAX) ? HOURS_MAX : raw;
    week_fill++;
    if (week_fill < DAYS) return;
    week_fill = 0;
    sum = 0;
    top_idx = 0;
    low_idx = 0;
    hits = 0;
    misses = 0;
    for (int i = 0; i < DAYS; i++) begin
      sum += week_vals[i];
      if (week_vals[i] > week_vals[top_idx]) top_idx = i;
      if (week_vals[i] < week_vals[low_idx]) low_idx = i;
      if (week_vals[i] >= goal_hours) hits++;
      else misses++;
      order[i] = week_vals[i];
    end
    for (int i = 0; i + 1 < DAYS; i++) begin
      for (int j = 0; j + 1 < DAYS; j++) begin
        if (order[j] < order[j+1]) begin
          swap = order[j];
          order[j] = order[j+1];
          order[j+1] = swap;
        end
      end
    end
    for (int k = 0; k < DAYS; k++) begin
      r.sorted   = order[k];
      r.last     = (k + 1 == DAYS);
      r.total    = TOTAL_W'(clip(sum, TOTAL_MAX));
      r.average  = HOURS_W'(sum / DAYS);
      r.busiest  = SMALL_W'(clip(top_idx, SMALL_MAX));
      r.lightest = SMALL_W'(clip(low_idx, SMALL_MAX));
      r.met      = SMALL_W'(clip(hits, SMALL_MAX));
      r.missed   = SMALL_W'(clip(misses, SMALL_MAX));
      ranked_days_due.push_back(r);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  function automatic bit send_gap();
    case (pace)
      PACE_SEND_GAPS: return $urandom_range(99) < 67;
      PACE_BOTH: return $urandom_range(99) < 15;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit recv_stall();
    case (pace)
      PACE_RECV_STALLS: return $urandom_range(99) < 67;
      PACE_BOTH: return $urandom_range(99) < 15;
      default: return 1'b0;
    endcase
  endfunction

  // monitor and checker
  always @(posedge clk_i) begin
    ranked_day_t want;
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= push && !full;
      if (push && !full) record_day(hours_i);
      if (pop && !empty) begin
        if (ranked_days_due.size() == 0) begin
          $error("result transaction with nothing expected: sorted_hours %0d",
                 sorted_hours_o);
          mismatches++;
        end else begin
          want = ranked_days_due.pop_front();
          check_field("sorted_hours", want.sorted, sorted_hours_o);
          check_field("last_out", want.last, last_out_o);
          check_field("total_hours", want.total, total_hours_o);
          check_field("average_hours", want.average, average_hours_o);
          check_field("busiest_day", want.busiest, busiest_day_o);
          check_field("lightest_day", want.lightest, lightest_day_o);
          check_field("met_count", want.met, met_count_o);
          check_field("missed_count", want.missed, missed_count_o);
        end
      end
    end
  end

  // input driver
  always @(negedge clk_i) begin
    logic               offer;
    logic [HOURS_W-1:0] val;
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (in_fire) void'(hours_backlog.pop_front());
      if (push && !in_fire) begin
        offer = 1'b1;
        val = hours_i;
      end else if (hours_backlog.size() != 0 && !send_gap()) begin
        offer = 1'b1;
        val = hours_backlog[0];
      end else begin
        offer = 1'b0;
        val = hours_i;
      end
      push <= offer;
      hours_i <= val;
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_taken != hold_req) begin
      hold_taken = hold_req;
      hold_left = HOLD_CYCLES;
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= !recv_stall();
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == TARGET_ADDR) goal_hours = data[HOURS_W-1:0];
  endtask

  task automatic check_target_read();
    logic [DATA_W-1:0] got;
    @(negedge clk_i);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = TARGET_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    check_field("target_hours", goal_hours, got);
  endtask

  task automatic add_week(input int unsigned d[DAYS]);
    for (int i = 0; i < DAYS; i++) hours_backlog.push_back(HOURS_W'(d[i]));
  endtask

  task automatic add_random_week();
    int unsigned flavor;
    int unsigned picks[3];
    int v;
    flavor = $urandom_range(9);
    for (int i = 0; i < 3; i++) picks[i] = $urandom_range(2047);
    for (int i = 0; i < DAYS; i++) begin
      case (flavor)
        6: v = ($urandom_range(1)) ? $urandom_range(2047, 1501) : $urandom_range(1500);
        7: v = picks[$urandom_range(2)];
        8: begin
          v = int'(goal_hours) + int'($urandom_range(4)) - 2;
          if (v < 0) v = 0;
          if (v > 2047) v = 2047;
        end
        9: v = ($urandom_range(2) == 0) ? 0 : ($urandom_range(1) ? 1500 : 2047);
        default: v = $urandom_range(1500);
      endcase
      hours_backlog.push_back(HOURS_W'(v));
    end
  endtask

  task automatic settle();
    while (hours_backlog.size() != 0 || ranked_days_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned weeks;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // saturation, ties and first-index picks at the reset target
    add_week('{0, 1500, 2047, 1501, 1024, 0, 1500});
    settle();
    check_target_read();
    // met on equality, upper write bits dropped
    apb_write(TARGET_ADDR, 32'hFFFF_F800 | 32'd1500);
    check_target_read();
    add_week('{1500, 1499, 1, 2, 1023, 1500, 750});
    settle();
    // target above range: every day missed
    apb_write(TARGET_ADDR, 32'd2047);
    add_week('{2047, 2047, 2047, 2047, 2047, 2047, 2047});
    settle();
    apb_write(SPARE_ADDR, 32'd5);
    check_target_read();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: pace = PACE_FREE;
        1: pace = PACE_SEND_GAPS;
        2: pace = PACE_RECV_STALLS;
        3: pace = PACE_BOTH;
        default: pace = PACE_FREE;
      endcase
      case (ph)
        0: apb_write(TARGET_ADDR, 32'd0);
        1: apb_write(TARGET_ADDR, 32'd1500);
        default: apb_write(TARGET_ADDR, $urandom_range(1600));
      endcase
      // long receiver hold-off so the block backs up and stalls its input
      if (ph == 4) hold_req++;
      weeks = (ph < 2) ? 10 : 9;
      for (int w = 0; w < weeks; w++) add_random_week();
      settle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
